// ----- rtl/core/sbsm_pkg.sv -----
// Shared types, constants and sizes for the side-by-side mask to RGBA converter.
package sbsm_pkg;

	localparam int MAX_CELL_WIDTH = 2048;
	localparam int MAX_ROW_WIDTH  = 4096;
	localparam int MAX_CELL_COUNT = 64;

	localparam int PIX_W  = 32;
	localparam int CW_W   = 12;
	localparam int CC_W   = 7;
	localparam int SW_W   = 13;
	localparam int AB_W   = 2;
	localparam int CFG_W  = 13;
	localparam int REG_W  = 2;
	localparam int IDX_W  = $clog2(MAX_CELL_WIDTH);
	localparam int COL_W  = $clog2(MAX_ROW_WIDTH);
	localparam int CELL_W = $clog2(MAX_CELL_COUNT);
	localparam int ACT_W  = CW_W + CC_W + 1;

	localparam int OPQ_DEPTH   = 4;
	localparam int OPQ_PTR_W   = $clog2(OPQ_DEPTH);
	localparam int OPQ_CNT_W   = $clog2(OPQ_DEPTH + 1);
	localparam int OUTQ_DEPTH  = 4;
	localparam int OUTQ_PTR_W  = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_CNT_W  = $clog2(OUTQ_DEPTH + 1);

	localparam logic [7:0] ALPHA_FULL = 8'd255;

	typedef enum logic [REG_W-1:0] {
		REG_CELL_WIDTH   = 2'd0,
		REG_CELL_COUNT   = 2'd1,
		REG_SOURCE_WIDTH = 2'd2,
		REG_ALPHA_BYTE   = 2'd3
	} reg_idx_t;

	typedef enum logic {
		OP_COLOR = 1'b0,
		OP_MASK  = 1'b1
	} op_kind_t;

	typedef struct packed {
		op_kind_t              kind;
		logic [IDX_W-1:0]      idx;
		logic [PIX_W-1:0]      data;
		logic                  row_end;
		logic [AB_W-1:0]       alpha_sel;
	} op_t;

	typedef struct packed {
		logic [PIX_W-1:0] word;
		logic             row_end;
	} out_t;

endpackage

// ----- rtl/core/sbsm_front.sv -----
// Front end: configuration registers, row position tracking and beat classification.
module sbsm_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [sbsm_pkg::REG_W-1:0]  cfg_addr,
	input  logic [sbsm_pkg::CFG_W-1:0]  cfg_wdata,
	input  logic                        take,
	input  logic [sbsm_pkg::PIX_W-1:0]  pixel,
	output logic                        op_push,
	output sbsm_pkg::op_t               op
);
	import sbsm_pkg::*;

	logic [CW_W-1:0]   cell_width_q;
	logic [CC_W-1:0]   cell_count_q;
	logic [SW_W-1:0]   source_width_q;
	logic [AB_W-1:0]   alpha_byte_q;

	logic [COL_W-1:0]  column_pos_q;
	logic [IDX_W-1:0]  offset_q;
	logic              in_mask_q;
	logic [CELL_W-1:0] cell_index_q;

	logic [CW_W-1:0]   cw;
	logic [CC_W-1:0]   cc;
	logic [SW_W-1:0]   sw;
	logic [ACT_W-1:0]  active_cols;
	logic              active;
	logic              last_col;
	logic              cells_done;
	logic [CW_W-1:0]   off_inc;
	logic              half_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_width_q   <= CW_W'(1);
			cell_count_q   <= CC_W'(1);
			source_width_q <= SW_W'(2);
			alpha_byte_q   <= AB_W'(3);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_CELL_WIDTH:   cell_width_q   <= cfg_wdata[CW_W-1:0];
				REG_CELL_COUNT:   cell_count_q   <= cfg_wdata[CC_W-1:0];
				REG_SOURCE_WIDTH: source_width_q <= cfg_wdata[SW_W-1:0];
				REG_ALPHA_BYTE:   alpha_byte_q   <= cfg_wdata[AB_W-1:0];
			endcase
		end
	end

	always_comb begin
		if (cell_width_q == '0) begin
			cw = CW_W'(1);
		end else if (cell_width_q > CW_W'(MAX_CELL_WIDTH)) begin
			cw = CW_W'(MAX_CELL_WIDTH);
		end else begin
			cw = cell_width_q;
		end
		if (cell_count_q == '0) begin
			cc = CC_W'(1);
		end else if (cell_count_q > CC_W'(MAX_CELL_COUNT)) begin
			cc = CC_W'(MAX_CELL_COUNT);
		end else begin
			cc = cell_count_q;
		end
		if (source_width_q == '0) begin
			sw = SW_W'(1);
		end else if (source_width_q > SW_W'(MAX_ROW_WIDTH)) begin
			sw = SW_W'(MAX_ROW_WIDTH);
		end else begin
			sw = source_width_q;
		end
	end

	always_comb begin
		active_cols = {(ACT_W-1)'(cw) * (ACT_W-1)'(cc), 1'b0};
		active      = (ACT_W'(column_pos_q) < active_cols)
			&& (CC_W'(cell_index_q) < cc);
		last_col    = (SW_W'(column_pos_q) + SW_W'(1)) >= sw;
		off_inc     = CW_W'(offset_q) + CW_W'(1);
		half_done   = off_inc >= cw;
		cells_done  = ((CC_W'(cell_index_q) + CC_W'(1)) >= cc) && half_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_pos_q <= '0;
			offset_q     <= '0;
			in_mask_q    <= 1'b0;
			cell_index_q <= '0;
		end else if (take) begin
			if (last_col) begin
				column_pos_q <= '0;
				offset_q     <= '0;
				in_mask_q    <= 1'b0;
				cell_index_q <= '0;
			end else begin
				column_pos_q <= column_pos_q + COL_W'(1);
				if (active) begin
					if (half_done) begin
						offset_q  <= '0;
						in_mask_q <= ~in_mask_q;
						if (in_mask_q) begin
							cell_index_q <= cell_index_q + CELL_W'(1);
						end
					end else begin
						offset_q <= off_inc[IDX_W-1:0];
					end
				end
			end
		end
	end

	always_comb begin
		op_push      = take && active;
		op.kind      = in_mask_q ? OP_MASK : OP_COLOR;
		op.idx       = offset_q;
		op.data      = pixel;
		op.row_end   = cells_done || last_col;
		op.alpha_sel = alpha_byte_q;
	end

endmodule

// ----- rtl/core/sbsm_opq.sv -----
// Short command queue between the front end and the line buffer back end.
module sbsm_opq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  sbsm_pkg::op_t wr_op,
	output logic          full,
	input  logic          rd_en,
	output sbsm_pkg::op_t rd_op,
	output logic          empty
);
	import sbsm_pkg::*;

	op_t                  slot_q [OPQ_DEPTH];
	logic [OPQ_PTR_W-1:0] wr_ptr_q;
	logic [OPQ_PTR_W-1:0] rd_ptr_q;
	logic [OPQ_CNT_W-1:0] count_q;

	assign full  = count_q == OPQ_CNT_W'(OPQ_DEPTH);
	assign empty = count_q == '0;
	assign rd_op = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0
					: wr_ptr_q + OPQ_PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0
					: rd_ptr_q + OPQ_PTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + OPQ_CNT_W'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - OPQ_CNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/core/sbsm_back.sv -----
// Back end: color line buffer, alpha merge and result queue.
module sbsm_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       op_empty,
	input  sbsm_pkg::op_t              op_head,
	output logic                       op_pop,
	input  logic                       pop,
	output logic                       empty,
	output logic [sbsm_pkg::PIX_W-1:0] rgba_pixel,
	output logic                       row_end
);
	import sbsm_pkg::*;

	logic [PIX_W-1:0]      color_line [MAX_CELL_WIDTH];

	logic                  vld_s1;
	logic [PIX_W-1:0]      color_s1;
	logic [7:0]            mask_s1;
	logic [AB_W-1:0]       alpha_sel_s1;
	logic                  row_end_s1;

	out_t                  outq_q [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0] wr_ptr_q;
	logic [OUTQ_PTR_W-1:0] rd_ptr_q;
	logic [OUTQ_CNT_W-1:0] count_q;

	logic                  room;
	logic                  take_mask;
	logic                  out_rd;
	out_t                  merged;

	always_comb begin
		room      = (count_q + OUTQ_CNT_W'(vld_s1)) < OUTQ_CNT_W'(OUTQ_DEPTH);
		op_pop    = !op_empty && ((op_head.kind == OP_COLOR) || room);
		take_mask = op_pop && (op_head.kind == OP_MASK);
		out_rd    = pop && !empty;
	end

	always_ff @(posedge clk) begin
		if (op_pop && (op_head.kind == OP_COLOR)) begin
			color_line[op_head.idx] <= op_head.data;
		end
		if (take_mask) begin
			color_s1 <= color_line[op_head.idx];
		end
	end

	always_ff @(posedge clk) begin
		if (take_mask) begin
			mask_s1      <= op_head.data[7:0];
			alpha_sel_s1 <= op_head.alpha_sel;
			row_end_s1   <= op_head.row_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= take_mask;
		end
	end

	always_comb begin
		logic [7:0] alpha;
		alpha = ALPHA_FULL - mask_s1;
		for (int b = 0; b < PIX_W / 8; b++) begin
			merged.word[b*8 +: 8] = (alpha_sel_s1 == AB_W'(b)) ? alpha : color_s1[b*8 +: 8];
		end
		merged.row_end = row_end_s1;
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			outq_q[wr_ptr_q] <= merged;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (vld_s1) begin
				wr_ptr_q <= (wr_ptr_q == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0
					: wr_ptr_q + OUTQ_PTR_W'(1);
			end
			if (out_rd) begin
				rd_ptr_q <= (rd_ptr_q == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0
					: rd_ptr_q + OUTQ_PTR_W'(1);
			end
			if (vld_s1 && !out_rd) begin
				count_q <= count_q + OUTQ_CNT_W'(1);
			end else if (out_rd && !vld_s1) begin
				count_q <= count_q - OUTQ_CNT_W'(1);
			end
		end
	end

	assign empty      = count_q == '0;
	assign rgba_pixel = outq_q[rd_ptr_q].word;
	assign row_end    = outq_q[rd_ptr_q].row_end;

endmodule

// ----- rtl/core/side_by_side_mask_to_rgba.sv -----
// Top level of the side-by-side color and mask to RGBA pixel converter.
//
//   channel   direction  handshake           payload
//   config    in         cfg_we              cfg_addr, cfg_wdata
//   source    in         push / full         pixel
//   result    out        empty / pop         rgba_pixel, row_end
//
// One source beat is taken every cycle while full is low; color and dropped pixels give no beat.
// After its mask pixel is taken, a result beat passes through the command queue, the line
// buffer read register and the result queue in that order.
// Reset clears row position and both queues and presets the registers; the line buffer is kept.
// A stalled result side fills the result queue, then the command queue, and then raises full.
module side_by_side_mask_to_rgba (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [sbsm_pkg::REG_W-1:0] cfg_addr,
	input  logic [sbsm_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                       push,
	output logic                       full,
	input  logic [sbsm_pkg::PIX_W-1:0] pixel,
	output logic                       empty,
	input  logic                       pop,
	output logic [sbsm_pkg::PIX_W-1:0] rgba_pixel,
	output logic                       row_end
);
	import sbsm_pkg::*;

	logic take;
	logic op_push;
	op_t  op_in;
	logic op_pop;
	op_t  op_head;
	logic op_empty;

	assign take = push && !full;

	sbsm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.take      (take),
		.pixel     (pixel),
		.op_push   (op_push),
		.op        (op_in)
	);

	sbsm_opq u_opq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (op_push),
		.wr_op  (op_in),
		.full   (full),
		.rd_en  (op_pop),
		.rd_op  (op_head),
		.empty  (op_empty)
	);

	sbsm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.op_empty   (op_empty),
		.op_head    (op_head),
		.op_pop     (op_pop),
		.pop        (pop),
		.empty      (empty),
		.rgba_pixel (rgba_pixel),
		.row_end    (row_end)
	);

endmodule

// ----- rtl/core/sbsm_checker.sv -----
// Port-level checker for the converter and the bind that attaches it.
module sbsm_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       push,
	input logic                       full,
	input logic                       empty,
	input logic                       pop,
	input logic [sbsm_pkg::PIX_W-1:0] rgba_pixel,
	input logic                       row_end
);

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> (empty && !full))
		else $error("queues not idle during reset");

	a_full_needs_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("full rose without a source beat");

	a_empty_needs_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(empty) |-> $past(pop))
		else $error("result vanished without a pop");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("waiting result beat withdrawn");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> ($stable(rgba_pixel) && $stable(row_end)))
		else $error("waiting result beat changed");

endmodule

bind side_by_side_mask_to_rgba sbsm_checker u_sbsm_checker (.*);
